### sv/spr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream pattern replacer package
// Shared widths, codes and the job word passed from front end to back end.
// ----------------------------------------------------------------------------
package spr_pkg;

  localparam int MAX_PATTERN     = 8;
  localparam int MAX_REPLACEMENT = 8;
  localparam int BYTE_W          = 8;
  localparam int LEN_W           = 4;
  localparam int REG_W           = 64;

  localparam int WIN_W     = BYTE_W * MAX_PATTERN;
  localparam int FILL_W    = $clog2(MAX_PATTERN + 1);
  localparam int JOB_BYTES = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
  localparam int JOB_W     = BYTE_W * JOB_BYTES;
  localparam int JCNT_W    = $clog2(JOB_BYTES + 1);
  localparam int IDX_W     = (JOB_BYTES > 1) ? $clog2(JOB_BYTES) : 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    CMD_DATA = 1'b0,
    CMD_END  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_PATTERN_LEN   = 2'd0,
    CFG_PATTERN_BYTES = 2'd1,
    CFG_REPL_LEN      = 2'd2,
    CFG_REPL_BYTES    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [LEN_W-1:0] pattern_len;
    logic [REG_W-1:0] pattern_bytes;
    logic [LEN_W-1:0] repl_len;
    logic [REG_W-1:0] repl_bytes;
  } cfg_t;

  // One job: emit cnt bytes of data, oldest first; flush marks the last one
  // as end of string (a flush with cnt of zero is a bare end marker).
  typedef struct packed {
    logic [JOB_W-1:0]  data;
    logic [JCNT_W-1:0] cnt;
    logic              flush;
  } job_t;

endpackage

### sv/stream_pattern_replacer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream pattern replacer top level
// Replaces each non-overlapping match of a pattern with a replacement string.
// ----------------------------------------------------------------------------
// The front end takes one input word per cycle (byte or end command) while the
// queue is not full, updates the match window in that cycle and queues at most
// one job in a four-entry queue. The back end turns each job into output words
// at one byte per cycle, while the receiver takes them, through a registered
// output: a passed byte gives one word, a match gives one word per replacement
// byte (none for an empty one), and an end command gives one word per byte still
// held in the window, or one bare end marker. s_axis_tready drops only while the
// queue is full, which happens while long replacements or flushes drain or the
// receiver stalls. A result passes through the job queue and the output register.
// Write the configuration only while no words are in flight.
module stream_pattern_replacer_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [spr_pkg::REG_W-1:0]   cfg_wdata_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [spr_pkg::BYTE_W-1:0]  s_axis_tdata,  // [7:0] in_byte
  input  logic                        s_axis_tuser,  // [0] cmd
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [spr_pkg::BYTE_W-1:0]  m_axis_tdata,  // [7:0] out_byte
  output logic                        m_axis_tuser,  // [0] has_byte
  output logic                        m_axis_tlast
);
  import spr_pkg::*;

  cfg_t cfg_q;
  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  job_t push_job;
  job_t head_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PATTERN_LEN:   cfg_q.pattern_len   <= cfg_wdata_i[LEN_W-1:0];
        CFG_PATTERN_BYTES: cfg_q.pattern_bytes <= cfg_wdata_i;
        CFG_REPL_LEN:      cfg_q.repl_len      <= cfg_wdata_i[LEN_W-1:0];
        CFG_REPL_BYTES:    cfg_q.repl_bytes    <= cfg_wdata_i;
        default:           cfg_q               <= cfg_q;
      endcase
    end
  end

  spr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_cmd_i   (s_axis_tuser),
    .in_byte_i  (s_axis_tdata),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  spr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (pop),
    .head_o     (head_job),
    .empty_o    (q_empty)
  );

  spr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_job),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_has_o   (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

### sv/spr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream pattern replacer job queue
// Small register FIFO of jobs between front end and back end.
// ----------------------------------------------------------------------------
module spr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  spr_pkg::job_t push_job_i,
  output logic          full_o,
  input  logic          pop_i,
  output spr_pkg::job_t head_o,
  output logic          empty_o
);
  import spr_pkg::*;

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job pushed into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("job popped from empty queue");
`endif

endmodule

### sv/spr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream pattern replacer front end
// Append each byte to the window, match against the pattern, issue jobs; an end command flushes the window.
// ----------------------------------------------------------------------------
module spr_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  spr_pkg::cfg_t                cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         in_cmd_i,
  input  logic [spr_pkg::BYTE_W-1:0]   in_byte_i,
  input  logic                         q_full_i,
  output logic                         push_o,
  output spr_pkg::job_t                job_o
);
  import spr_pkg::*;

  logic [WIN_W-1:0]  win_q, win_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [WIN_W-1:0]  win_app;
  logic [FILL_W-1:0] fill_app;
  logic [FILL_W-1:0] plen;
  logic [JCNT_W-1:0] rlen;
  logic              accept;
  logic              all_eq;
  logic              decide;
  logic              matched;
  logic              issue;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept && issue;

  assign plen = (cfg_i.pattern_len > LEN_W'(MAX_PATTERN)) ? FILL_W'(MAX_PATTERN)
                                                          : FILL_W'(cfg_i.pattern_len);
  assign rlen = (cfg_i.repl_len > LEN_W'(MAX_REPLACEMENT)) ? JCNT_W'(MAX_REPLACEMENT)
                                                           : JCNT_W'(cfg_i.repl_len);

  always_comb begin
    fill_app = fill_q + FILL_W'(1);
    all_eq   = 1'b1;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      win_app[k*BYTE_W +: BYTE_W] = (FILL_W'(k) == fill_q) ? in_byte_i
                                                           : win_q[k*BYTE_W +: BYTE_W];
    end
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if ((FILL_W'(k) < plen) &&
          (win_app[k*BYTE_W +: BYTE_W] != cfg_i.pattern_bytes[k*BYTE_W +: BYTE_W])) begin
        all_eq = 1'b0;
      end
    end
    decide  = (plen == '0) || (fill_app >= plen);
    matched = (plen != '0) && decide && all_eq;
  end

  always_comb begin
    job_o  = '0;
    issue  = 1'b0;
    win_d  = win_q;
    fill_d = fill_q;
    if (cmd_e'(in_cmd_i) == CMD_END) begin
      job_o.data  = JOB_W'(win_q);
      job_o.cnt   = JCNT_W'(fill_q);
      job_o.flush = 1'b1;
      issue       = 1'b1;
      fill_d      = '0;
    end else if (matched) begin
      job_o.data = JOB_W'(cfg_i.repl_bytes);
      job_o.cnt  = rlen;
      issue      = (rlen != '0);
      win_d      = win_app >> (BYTE_W * plen);
      fill_d     = fill_app - plen;
    end else if (decide) begin
      job_o.data = JOB_W'(win_app[BYTE_W-1:0]);
      job_o.cnt  = JCNT_W'(1);
      issue      = 1'b1;
      win_d      = win_app >> BYTE_W;
      fill_d     = fill_app - FILL_W'(1);
    end else begin
      win_d  = win_app;
      fill_d = fill_app;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      fill_q <= '0;
    end else if (accept) begin
      win_q  <= win_d;
      fill_q <= fill_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < FILL_W'(MAX_PATTERN))
    else $error("window holds a full pattern after a step");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_cmd_i) |=> (fill_q == '0))
    else $error("window not cleared by end of string");

  a_pass_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !in_cmd_i && (plen == '0)) |-> (push_o && (job_o.cnt == JCNT_W'(1))))
    else $error("pass-through byte not issued");
`endif

endmodule

### sv/spr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream pattern replacer back end
// Expand queued jobs into output words, one byte per cycle while the receiver takes them.
// ----------------------------------------------------------------------------
module spr_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  spr_pkg::job_t                head_i,
  input  logic                         empty_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [spr_pkg::BYTE_W-1:0]   out_byte_o,
  output logic                         out_has_o,
  output logic                         out_last_o
);
  import spr_pkg::*;

  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              ovalid_q, ovalid_d;
  logic [BYTE_W-1:0] obyte_q, obyte_d;
  logic              ohas_q, ohas_d;
  logic              olast_q, olast_d;
  logic              load;
  logic              last;
  logic              bare;

  assign bare  = (head_i.cnt == '0);
  assign last  = bare || ((JCNT_W'(idx_q) + JCNT_W'(1)) == head_i.cnt);
  assign load  = !empty_i && (!ovalid_q || out_ready_i);
  assign pop_o = load && last;

  always_comb begin
    idx_d    = idx_q;
    ovalid_d = ovalid_q;
    obyte_d  = obyte_q;
    ohas_d   = ohas_q;
    olast_d  = olast_q;
    if (load) begin
      ovalid_d = 1'b1;
      obyte_d  = bare ? '0 : head_i.data[idx_q*BYTE_W +: BYTE_W];
      ohas_d   = !bare;
      olast_d  = head_i.flush && last;
      idx_d    = last ? '0 : idx_q + IDX_W'(1);
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obyte_q <= obyte_d;
    ohas_q  <= ohas_d;
    olast_q <= olast_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_byte_o  = obyte_q;
  assign out_has_o   = ohas_q;
  assign out_last_o  = olast_q;

`ifndef NO_ASSERTIONS
  a_bare_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !ohas_q) |-> olast_q)
    else $error("bare marker without end of string");

  a_idx_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_i && !bare) |-> (JCNT_W'(idx_q) < head_i.cnt))
    else $error("byte index beyond job length");

  a_pop_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (idx_q == '0))
    else $error("byte index not rewound after job");
`endif

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream pattern replacer testbench
// Feeds byte strings and end commands through the replacer under a series of
// pattern and replacement settings, starting with a short directed table and
// going on to random strings built from pattern pieces. A behavioural
// predictor works out the rewritten output for every accepted word; each
// output word is compared field by field, in order. Both sides idle at random,
// the receiver holds off once for a long stretch and the sender pauses once
// until the output has drained.
// ----------------------------------------------------------------------------
module tb_top;
  import spr_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int LIMIT        = 400000;
  localparam int PHASES       = 7;
  localparam int PHASE_WORDS  = 42;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              has_byte;
    logic              end_mark;
  } out_word_t;

  typedef enum logic {ROW_REG, ROW_WORD} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    cfg_idx_e          idx;
    logic [REG_W-1:0]  value;
    cmd_e              cmd;
    logic [BYTE_W-1:0] data;
    bit                typed;
    out_word_t         want;
  } row_t;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              cfg_we    = 1'b0;
  cfg_idx_e          cfg_idx   = CFG_PATTERN_LEN;
  logic [REG_W-1:0]  cfg_wdata = '0;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [BYTE_W-1:0] s_tdata   = '0;
  cmd_e              s_tuser   = CMD_DATA;
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [BYTE_W-1:0] m_tdata;
  logic              m_tuser;
  logic              m_tlast;
  bit                word_typed = 1'b0;
  out_word_t         word_want  = '0;

  logic [LEN_W-1:0] pat_len   = '0;
  logic [REG_W-1:0] pat_bytes = '0;
  logic [LEN_W-1:0] rep_len   = '0;
  logic [REG_W-1:0] rep_bytes = '0;
  logic [WIN_W-1:0] win_bytes = '0;
  int               win_fill  = 0;
  out_word_t        pending_out[$];
  row_t             script[$];

  int mismatches   = 0;
  int words_in     = 0;
  int words_out    = 0;
  int offered      = 0;
  int reg_writes   = 0;
  int replacements = 0;
  int cycles       = 0;
  bit tx_idle_on   = 1'b1;
  bit rx_idle_on   = 1'b1;
  bit rx_hold_req  = 1'b0;

  always #1 clk_i = ~clk_i;

  stream_pattern_replacer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast)
  );

  function automatic logic [WIN_W-1:0] low_mask(int n);
    if (n >= MAX_PATTERN) return '1;
    return (64'd1 << (BYTE_W * n)) - 64'd1;
  endfunction

  task automatic rewrite_word(cmd_e c, logic [BYTE_W-1:0] b);
    int plen;
    int rlen;
    logic [WIN_W-1:0] m;
    plen = (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
    rlen = (rep_len > MAX_REPLACEMENT) ? MAX_REPLACEMENT : int'(rep_len);
    if (c == CMD_END) begin
      if (win_fill == 0) begin
        pending_out.push_back(out_word_t'{8'h00, 1'b0, 1'b1});
      end else begin
        for (int i = 0; i < win_fill; i++)
          pending_out.push_back(out_word_t'{win_bytes[8*i +: 8], 1'b1, i == win_fill - 1});
      end
      win_bytes = '0;
      win_fill  = 0;
    end else begin
      win_bytes = (win_bytes & low_mask(win_fill)) | ({56'd0, b} << (BYTE_W * win_fill));
      win_fill++;
      if (plen == 0 || win_fill >= plen) begin
        m = low_mask(plen);
        if (plen != 0 && (win_bytes & m) == (pat_bytes & m)) begin
          for (int i = 0; i < rlen; i++)
            pending_out.push_back(out_word_t'{rep_bytes[8*i +: 8], 1'b1, 1'b0});
          win_bytes = (plen >= MAX_PATTERN) ? '0 : win_bytes >> (BYTE_W * plen);
          win_fill -= plen;
          replacements++;
        end else begin
          pending_out.push_back(out_word_t'{win_bytes[7:0], 1'b1, 1'b0});
          win_bytes = win_bytes >> BYTE_W;
          win_fill--;
        end
      end
    end
  endtask

  function automatic void check_field(string field, logic [BYTE_W-1:0] want,
                                      logic [BYTE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    int prior;
    out_word_t want;
    if (rst_ni && s_tvalid && s_tready) begin
      prior = pending_out.size();
      rewrite_word(s_tuser, s_tdata);
      words_in++;
      if (word_typed) begin
        while (pending_out.size() > prior) void'(pending_out.pop_back());
        pending_out.push_back(word_want);
      end
    end
    if (rst_ni && m_tvalid && m_tready) begin
      words_out++;
      if (pending_out.size() == 0) begin
        $error("output word %0h arrived with nothing expected", m_tdata);
        mismatches++;
      end else begin
        want = pending_out.pop_front();
        check_field("out_byte", want.data, m_tdata);
        check_field("has_byte", BYTE_W'(want.has_byte), BYTE_W'(m_tuser));
        check_field("end_mark", BYTE_W'(want.end_mark), BYTE_W'(m_tlast));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $error("timeout with %0d output words still expected", pending_out.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end
      gap = rx_idle_on ? $urandom_range(0, 18) : 0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
    end
  end

  task automatic send_word(cmd_e c, logic [BYTE_W-1:0] b, bit typed = 1'b0,
                           out_word_t want = '0);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid   <= 1'b1;
    s_tdata    <= b;
    s_tuser    <= c;
    word_typed <= typed;
    word_want  <= want;
    offered++;
    do @(posedge clk_i); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_out.size() != 0) @(posedge clk_i);
  endtask

  // leaves the write enable high; the caller drops it after the last register
  task automatic set_reg(cfg_idx_e idx, logic [REG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk_i);
    case (idx)
      CFG_PATTERN_LEN:   pat_len   = v[LEN_W-1:0];
      CFG_PATTERN_BYTES: pat_bytes = v;
      CFG_REPL_LEN:      rep_len   = v[LEN_W-1:0];
      CFG_REPL_BYTES:    rep_bytes = v;
      default:           ;
    endcase
    reg_writes++;
  endtask

  task automatic add_reg(cfg_idx_e idx, logic [REG_W-1:0] v);
    script.push_back(row_t'{ROW_REG, idx, v, CMD_DATA, 8'h00, 1'b0, '0});
  endtask

  task automatic add_word(cmd_e c, logic [BYTE_W-1:0] b, bit typed = 1'b0,
                          out_word_t want = '0);
    script.push_back(row_t'{ROW_WORD, CFG_PATTERN_LEN, '0, c, b, typed, want});
  endtask

  initial begin
    bit               reg_open;
    bit               hold_done;
    bit               pause_done;
    int               plen;
    int               rlen;
    int               span;
    int               pieces;
    int               kind;
    int               cut;
    int               phase_start;
    logic [REG_W-1:0] pbytes;
    logic [REG_W-1:0] rbytes;
    logic [BYTE_W-1:0] b;

    // straight after reset the block passes bytes through
    add_word(CMD_DATA, 8'h00, 1'b1, out_word_t'{8'h00, 1'b1, 1'b0});
    add_word(CMD_DATA, 8'hFF, 1'b1, out_word_t'{8'hFF, 1'b1, 1'b0});
    add_word(CMD_END,  8'hFF, 1'b1, out_word_t'{8'h00, 1'b0, 1'b1});
    add_reg(CFG_PATTERN_LEN, 64'd3);
    add_reg(CFG_PATTERN_BYTES, 64'h0000_0000_0063_6261);
    add_reg(CFG_REPL_LEN, 64'd8);
    add_reg(CFG_REPL_BYTES, 64'h00FF_A55A_0180_7F01);
    add_word(CMD_DATA, 8'h61);
    add_word(CMD_DATA, 8'h61);
    add_word(CMD_DATA, 8'h62);
    add_word(CMD_DATA, 8'h63);
    add_reg(CFG_REPL_LEN, 64'd0);
    add_word(CMD_DATA, 8'h61);
    add_word(CMD_DATA, 8'h62);
    add_word(CMD_DATA, 8'h63);
    add_word(CMD_END,  8'h00, 1'b1, out_word_t'{8'h00, 1'b0, 1'b1});
    // lengths above the limit act as eight
    add_reg(CFG_PATTERN_LEN, 64'd15);
    add_reg(CFG_PATTERN_BYTES, 64'h00FF_00FF_FF00_FF00);
    add_reg(CFG_REPL_LEN, 64'd15);
    add_reg(CFG_REPL_BYTES, 64'h8000_0000_0000_0001);
    for (int k = 0; k < MAX_PATTERN; k++)
      add_word(CMD_DATA, BYTE_W'(64'h00FF_00FF_FF00_FF00 >> (8*k)));
    add_word(CMD_DATA, 8'h11);
    add_word(CMD_DATA, 8'h22);
    add_word(CMD_DATA, 8'h33);
    // shorten the pattern with bytes still held in the window
    add_reg(CFG_PATTERN_LEN, 64'd2);
    add_reg(CFG_PATTERN_BYTES, 64'h0000_0000_0000_2211);
    add_word(CMD_DATA, 8'h44);
    add_word(CMD_END,  8'h5A);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    reg_open = 1'b0;
    foreach (script[r]) begin
      if (script[r].kind == ROW_REG) begin
        if (!reg_open) begin
          drain();
          repeat (DRAIN_CYCLES) @(posedge clk_i);
        end
        set_reg(script[r].idx, script[r].value);
        reg_open = 1'b1;
      end else begin
        if (reg_open) cfg_we <= 1'b0;
        reg_open = 1'b0;
        send_word(script[r].cmd, script[r].data, script[r].typed, script[r].want);
      end
    end

    hold_done  = 1'b0;
    pause_done = 1'b0;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin plen = 1;  rlen = 8;  end
        1: begin plen = 8;  rlen = 1;  end
        2: begin plen = 0;  rlen = $urandom_range(0, 15); end
        3: begin plen = 15; rlen = 15; end
        4: begin plen = 2;  rlen = 0;  end
        default: begin
          plen = $urandom_range(0, 15);
          rlen = $urandom_range(0, 15);
        end
      endcase
      pbytes = {$urandom, $urandom};
      if (ph == 3) pbytes = '1;
      if (ph == 4) pbytes = '0;
      rbytes = {$urandom, $urandom};
      tx_idle_on = (ph % 3 != 1);
      rx_idle_on = (ph % 3 != 2);

      drain();
      repeat (DRAIN_CYCLES) @(posedge clk_i);
      set_reg(CFG_PATTERN_LEN, REG_W'(plen));
      set_reg(CFG_PATTERN_BYTES, pbytes);
      set_reg(CFG_REPL_LEN, REG_W'(rlen));
      set_reg(CFG_REPL_BYTES, rbytes);
      cfg_we <= 1'b0;

      span = (plen > MAX_PATTERN) ? MAX_PATTERN : plen;
      phase_start = offered;
      while (offered - phase_start < PHASE_WORDS) begin
        if (ph == 1 && offered - phase_start >= 10 && !hold_done) begin
          rx_hold_req = 1'b1;
          hold_done   = 1'b1;
        end
        if (ph == 5 && offered - phase_start >= 20 && !pause_done) begin
          drain();
          pause_done = 1'b1;
        end
        pieces = $urandom_range(0, 6);
        repeat (pieces) begin
          kind = $urandom_range(0, 9);
          if (kind <= 3)      cut = span;
          else if (kind <= 5) cut = $urandom_range(0, span);
          else                cut = 0;
          for (int k = 0; k < cut; k++) send_word(CMD_DATA, pbytes[8*k +: 8]);
          if (cut == 0) begin
            if (kind == 9 || span == 0) b = BYTE_W'($urandom_range(0, 255));
            else                        b = pbytes[8*$urandom_range(0, span - 1) +: 8];
            send_word(CMD_DATA, b);
          end
        end
        // leave a string open now and then so the next setting meets a window still holding bytes
        if ($urandom_range(0, 9) != 0 || ph == PHASES - 1)
          send_word(CMD_END, BYTE_W'($urandom_range(0, 255)));
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d input words and %0d output words over %0d register writes",
             words_in, words_out, reg_writes);
    $display("%0d replacements, one %0d-cycle receiver hold, one sender pause to drain",
             replacements, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### sim.f
sv/spr_pkg.sv
sv/spr_queue.sv
sv/spr_front.sv
sv/spr_back.sv
sv/stream_pattern_replacer_top.sv
tb/sv/tb_top.sv
